/* design/ahrf_pkg.sv */
// Shared types, codes and defaults for the attack/hold/return fade envelope.
// No dependencies; imported by every other file of the block but ahrf_stream_if.
`default_nettype none

package ahrf_pkg;

  localparam int unsigned TIME_WIDTH_DEF  = 16;
  localparam int unsigned LEVEL_WIDTH_DEF = 16;

  // Configuration registers, lengths and beat fields are fixed at 16 bits.
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned FLD_W  = 16;
  localparam int unsigned CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_TOTAL  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ATTACK = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_RETURN = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_MAXLVL = 2'd3;

  localparam logic [CFG_W-1:0] TOTAL_RST  = 16'd500;
  localparam logic [CFG_W-1:0] ATTACK_RST = 16'd50;
  localparam logic [CFG_W-1:0] RETURN_RST = 16'd300;
  localparam logic [CFG_W-1:0] MAXLVL_RST = 16'd45875;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_EARLY = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ATTACK = 3'd1,
    PH_HOLD   = 3'd2,
    PH_RETURN = 3'd3,
    PH_EARLY  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CALC,
    ST_WRITE
  } ctrl_state_e;

  typedef struct packed {
    action_e          action;
    logic [FLD_W-1:0] tick_delta;
    logic [FLD_W-1:0] return_length;
  } in_item_t;

  typedef struct packed {
    logic [FLD_W-1:0] level;
    logic             active;
    logic [2:0]       phase;
  } out_item_t;

endpackage

`default_nettype wire

/* design/ahrf_stream_if.sv */
// Valid/ready stream channel carrying one payload per beat.
// Payload type given by parameter; used with ahrf_pkg item structs.
`default_nettype none

interface ahrf_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/attack_hold_release_fade.sv */
// Attack/hold/return fade envelope for a dimming level, one result beat per input beat.
// Flow: a beat is captured in IDLE and evaluated in EVAL; a ramp level is computed in CALC
//   by the bit-serial multiply/divide; the result is registered in WRITE.
// One item in flight: the next beat is taken only after the result of the last is loaded,
//   so a stalled result beat also holds the input.
// Reset (async, active low): idle, level 0, registers at 500 / 50 / 300 / 45875.
// Depends on ahrf_pkg, ahrf_stream_if and ahrf_muldiv.
`default_nettype none

module attack_hold_release_fade #(
  parameter int unsigned TIME_WIDTH  = ahrf_pkg::TIME_WIDTH_DEF,
  parameter int unsigned LEVEL_WIDTH = ahrf_pkg::LEVEL_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ahrf_pkg::CFG_IW-1:0] cfg_idx_i,
  input  wire logic [ahrf_pkg::CFG_W-1:0]  cfg_data_i,
  ahrf_stream_if.sink                      in_i,
  ahrf_stream_if.source                    out_o
);
  import ahrf_pkg::*;

  // Multiplicand width: the peak register is 16 bits, the captured level LEVEL_WIDTH.
  localparam int unsigned A_W   = (LEVEL_WIDTH > FLD_W) ? LEVEL_WIDTH : FLD_W;
  // Width for comparing the timer against 16-bit lengths, plus a carry bit for the add.
  localparam int unsigned CMP_W = (TIME_WIDTH > FLD_W) ? TIME_WIDTH : FLD_W;
  localparam int unsigned SUM_W = CMP_W + 1;
  localparam int unsigned HLD_W = FLD_W + 2;

  // Configuration
  logic [CFG_W-1:0] total_q, attack_q, return_q, maxlvl_q;

  // Envelope state
  phase_e                 phase_q, phase_d;
  logic [TIME_WIDTH-1:0]  timer_q, timer_d;
  logic [LEVEL_WIDTH-1:0] level_q, level_d;
  logic [LEVEL_WIDTH-1:0] rstart_q, rstart_d;
  logic [FLD_W-1:0]       rlen_q, rlen_d;
  logic                   running_q, running_d;

  // Control and captured beat
  ctrl_state_e st_q, st_d;
  in_item_t    item_q;
  out_item_t   out_q;
  logic        out_valid_q, out_valid_d;
  logic        out_load;

  // Serial unit
  logic             md_start;
  logic [A_W-1:0]   md_a;
  logic [FLD_W-1:0] md_b, md_c;
  logic             md_done;
  logic [A_W-1:0]   md_quot;

  // Tick arithmetic
  logic [SUM_W-1:0]      t_sum;
  logic [TIME_WIDTH-1:0] nt;
  logic [CMP_W-1:0]      nt_c;
  logic signed [HLD_W-1:0] hold_s;
  logic                  hold_pos;

  always_comb begin
    t_sum    = SUM_W'(timer_q) + SUM_W'(item_q.tick_delta);
    // saturate the phase timer
    nt       = (|t_sum[SUM_W-1:TIME_WIDTH]) ? '1 : t_sum[TIME_WIDTH-1:0];
    nt_c     = CMP_W'(nt);
    hold_s   = $signed({2'b00, total_q}) - $signed({2'b00, attack_q})
             - $signed({2'b00, return_q});
    hold_pos = !hold_s[HLD_W-1] && (hold_s != '0);
  end

  ahrf_muldiv #(
    .A_W (A_W)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .c_i     (md_c),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  // Control FSM: capture beat, evaluate action, optional serial ramp, write result.
  always_comb begin
    st_d      = st_q;
    phase_d   = phase_q;
    timer_d   = timer_q;
    level_d   = level_q;
    rstart_d  = rstart_q;
    rlen_d    = rlen_q;
    running_d = running_q;
    md_start  = 1'b0;
    md_a      = A_W'(maxlvl_q);
    md_b      = FLD_W'(nt);
    md_c      = attack_q;
    out_load  = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          st_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        st_d = ST_WRITE;
        unique case (item_q.action)
          ACT_TICK: begin
            if (!running_q || phase_q == PH_IDLE) begin
              phase_d   = PH_IDLE;
              timer_d   = '0;
              level_d   = '0;
              running_d = 1'b0;
            end else begin
              timer_d = nt;
              case (phase_q)
                PH_ATTACK: begin
                  if (attack_q == '0 || nt_c >= CMP_W'(attack_q)) begin
                    phase_d = PH_HOLD;
                    timer_d = '0;
                    level_d = LEVEL_WIDTH'(maxlvl_q);
                  end else begin
                    md_start = 1'b1;
                    st_d     = ST_CALC;
                  end
                end
                PH_HOLD: begin
                  level_d = LEVEL_WIDTH'(maxlvl_q);
                  if (!hold_pos || nt_c >= CMP_W'(hold_s[FLD_W-1:0])) begin
                    phase_d = PH_RETURN;
                    timer_d = '0;
                  end
                end
                PH_RETURN: begin
                  if (return_q == '0 || nt_c >= CMP_W'(return_q)) begin
                    phase_d   = PH_IDLE;
                    timer_d   = '0;
                    level_d   = '0;
                    running_d = 1'b0;
                  end else begin
                    md_b     = return_q - FLD_W'(nt);
                    md_c     = return_q;
                    md_start = 1'b1;
                    st_d     = ST_CALC;
                  end
                end
                PH_EARLY: begin
                  if (rlen_q == '0 || nt_c >= CMP_W'(rlen_q)) begin
                    phase_d   = PH_IDLE;
                    timer_d   = '0;
                    level_d   = '0;
                    running_d = 1'b0;
                  end else begin
                    md_a     = A_W'(rstart_q);
                    md_b     = rlen_q - FLD_W'(nt);
                    md_c     = rlen_q;
                    md_start = 1'b1;
                    st_d     = ST_CALC;
                  end
                end
                default: begin
                  phase_d   = PH_IDLE;
                  timer_d   = '0;
                  level_d   = '0;
                  running_d = 1'b0;
                end
              endcase
            end
          end
          ACT_START: begin
            phase_d   = PH_ATTACK;
            timer_d   = '0;
            level_d   = '0;
            running_d = 1'b1;
          end
          ACT_STOP: begin
            phase_d   = PH_IDLE;
            timer_d   = '0;
            level_d   = '0;
            running_d = 1'b0;
          end
          ACT_EARLY: begin
            // ignored while idle; otherwise ramp down from the present level
            if (running_q && phase_q != PH_IDLE) begin
              phase_d  = PH_EARLY;
              timer_d  = '0;
              rstart_d = level_q;
              rlen_d   = item_q.return_length;
            end
          end
          default: ;
        endcase
      end

      ST_CALC: begin
        if (md_done) begin
          level_d = LEVEL_WIDTH'(md_quot);
          st_d    = ST_WRITE;
        end
      end

      ST_WRITE: begin
        // wait here only while the previous result beat is still unclaimed
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= TOTAL_RST;
      attack_q <= ATTACK_RST;
      return_q <= RETURN_RST;
      maxlvl_q <= MAXLVL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOTAL:  total_q  <= cfg_data_i;
        CFG_ATTACK: attack_q <= cfg_data_i;
        CFG_RETURN: return_q <= cfg_data_i;
        CFG_MAXLVL: maxlvl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_IDLE;
      timer_q     <= '0;
      level_q     <= '0;
      rstart_q    <= '0;
      rlen_q      <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      level_q     <= level_d;
      rstart_q    <= rstart_d;
      rlen_q      <= rlen_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_i.valid) begin
      item_q <= in_i.data;
    end
    if (out_load) begin
      out_q.level  <= FLD_W'(level_q);
      out_q.active <= running_q;
      out_q.phase  <= phase_q;
    end
  end

  assign in_i.ready  = (st_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

/* design/ahrf_muldiv.sv */
// Bit-serial floor(a * b / c): shift-add multiply, then restoring divide.
// Requires b <= c so the quotient fits A_W bits. Uses ahrf_pkg.
`default_nettype none

module ahrf_muldiv #(
  parameter int unsigned A_W = ahrf_pkg::LEVEL_WIDTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [A_W-1:0]            a_i,
  input  wire logic [ahrf_pkg::FLD_W-1:0] b_i,
  input  wire logic [ahrf_pkg::FLD_W-1:0] c_i,
  output logic                           done_o,
  output logic [A_W-1:0]                 quot_o
);
  import ahrf_pkg::*;

  localparam int unsigned P_W   = A_W + FLD_W;
  localparam int unsigned CNT_W = $clog2(P_W + 1);

  logic [P_W-1:0]   p_q, p_d;
  logic [A_W-1:0]   a_q;
  logic [FLD_W-1:0] c_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic             mul_ph;
  logic [A_W:0]     sum;
  logic [FLD_W:0]   r2;
  logic             ge;
  logic [FLD_W:0]   rnew;

  // multiply steps while more than A_W steps remain
  assign mul_ph = (cnt_q > CNT_W'(A_W));

  always_comb begin
    sum  = {1'b0, p_q[P_W-1:FLD_W]} + (p_q[0] ? {1'b0, a_q} : '0);
    r2   = {p_q[P_W-1:A_W], p_q[A_W-1]};
    ge   = (r2 >= {1'b0, c_q});
    rnew = ge ? (r2 - {1'b0, c_q}) : r2;

    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      p_d    = {{A_W{1'b0}}, b_i};
      cnt_d  = CNT_W'(P_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (mul_ph) begin
        p_d = {sum, p_q[FLD_W-1:1]};
      end else begin
        p_d = {rnew[FLD_W-1:0], p_q[A_W-2:0], ge};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (start_i) begin
      a_q <= a_i;
      c_q <= c_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = p_q[A_W-1:0];

endmodule

`default_nettype wire

/* sim/attack_hold_release_fade_test.sv */
// Self-checking bench for attack_hold_release_fade: directed and random action beats.
// A built-in envelope predictor checks every result beat in order.
// Depends on ahrf_pkg, ahrf_stream_if and the block itself.

module attack_hold_release_fade_test;
  import ahrf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 48;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IW-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;

  ahrf_stream_if #(.item_t(in_item_t))  in_ch ();
  ahrf_stream_if #(.item_t(out_item_t)) out_ch ();

  attack_hold_release_fade i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Action beats waiting to be sent, and predicted result beats in order.
  in_item_t  fade_actions[$];
  out_item_t envelope_due[$];

  // Idle/stall rates in percent, changed only between rounds.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  int mismatch_count = 0;
  int beat_count     = 0;
  int cycle_count    = 0;

  // Shadow of the configuration registers, at their reset values.
  logic [15:0] cfg_total  = TOTAL_RST;
  logic [15:0] cfg_attack = ATTACK_RST;
  logic [15:0] cfg_return = RETURN_RST;
  logic [15:0] cfg_peak   = MAXLVL_RST;

  // Predicted envelope state.
  phase_e      env_phase   = PH_IDLE;
  logic [15:0] env_timer   = '0;
  logic [15:0] env_level   = '0;
  logic [15:0] esc_start   = '0;  // level captured by an early return
  logic [15:0] esc_len     = '0;  // ramp length of that early return
  bit          env_running = 1'b0;

  out_item_t   level_want;

  // ---------------------------------------------------------------------------
  // Envelope predictor
  // ---------------------------------------------------------------------------

  // floor(a * b / den), exact in 64 bits; den is never zero here.
  function automatic logic [15:0] ratio(input logic [15:0] a, b, den);
    logic [63:0] prod;
    prod = {48'd0, a} * {48'd0, b};
    prod = prod / {48'd0, den};
    return prod[15:0];
  endfunction

  task automatic env_to_idle();
    env_phase   = PH_IDLE;
    env_timer   = '0;
    env_level   = '0;
    env_running = 1'b0;
  endtask

  // Linear ramp from top to zero over len; finishing (or zero len) drops to idle.
  task automatic ramp_to_zero(input logic [15:0] top, len);
    if (len == 0 || env_timer >= len) begin
      env_to_idle();
    end else begin
      env_level = ratio(top, len - env_timer, len);
    end
  endtask

  task automatic step_envelope(input in_item_t act);
    logic [16:0] sum;
    int          hold_len;
    out_item_t   res;
    case (act.action)
      ACT_TICK: begin
        if (!env_running || env_phase == PH_IDLE) begin
          env_to_idle();
        end else begin
          // timer saturates; surplus time past a phase end is dropped
          sum       = {1'b0, env_timer} + {1'b0, act.tick_delta};
          env_timer = sum[16] ? 16'hFFFF : sum[15:0];
          case (env_phase)
            PH_ATTACK: begin
              if (cfg_attack == 0 || env_timer >= cfg_attack) begin
                env_phase = PH_HOLD;
                env_timer = '0;
                env_level = cfg_peak;
              end else begin
                env_level = ratio(cfg_peak, env_timer, cfg_attack);
              end
            end
            PH_HOLD: begin
              env_level = cfg_peak;
              // signed hold length; zero or negative ends on the first tick
              hold_len = int'(cfg_total) - int'(cfg_attack) - int'(cfg_return);
              if (hold_len <= 0 || int'(env_timer) >= hold_len) begin
                env_phase = PH_RETURN;
                env_timer = '0;
              end
            end
            PH_RETURN: ramp_to_zero(cfg_peak, cfg_return);
            PH_EARLY:  ramp_to_zero(esc_start, esc_len);
            default:   env_to_idle();
          endcase
        end
      end
      ACT_START: begin
        // restarts from zero even mid-fade
        env_phase   = PH_ATTACK;
        env_timer   = '0;
        env_level   = '0;
        env_running = 1'b1;
      end
      ACT_STOP: env_to_idle();
      default: begin
        // early return: ignored while idle, restarts from current level otherwise
        if (env_running && env_phase != PH_IDLE) begin
          env_phase = PH_EARLY;
          env_timer = '0;
          esc_start = env_level;
          esc_len   = act.return_length;
        end
      end
    endcase
    res.level  = env_level;
    res.active = env_running;
    res.phase  = env_phase;
    envelope_due.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: sends queued action beats, predicts each one as it is accepted
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      step_envelope(in_ch.data);
    end
    // load a new beat only when the slot is empty or being taken now
    if (!in_ch.valid || in_ch.ready) begin
      if (fade_actions.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= fade_actions.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, in-order compare against predictions
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] got, want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("mismatch at result beat %0d: %s got %0h, want %0h",
               beat_count, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (envelope_due.size() == 0) begin
        report_mismatch("beat with nothing predicted, level", out_ch.data.level, '0);
      end else begin
        level_want = envelope_due.pop_front();
        if (out_ch.data.level !== level_want.level) begin
          report_mismatch("level", out_ch.data.level, level_want.level);
        end
        if (out_ch.data.active !== level_want.active) begin
          report_mismatch("active", {15'd0, out_ch.data.active}, {15'd0, level_want.active});
        end
        if (out_ch.data.phase !== level_want.phase) begin
          report_mismatch("phase", {13'd0, out_ch.data.phase}, {13'd0, level_want.phase});
        end
      end
      beat_count++;
    end
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_action(input action_e act, input logic [15:0] delta, rlen);
    in_item_t it;
    it.action        = act;
    it.tick_delta    = delta;
    it.return_length = rlen;
    fade_actions.push_back(it);
  endtask

  // Typical step size: a quarter of the longest phase, so sequences walk the ramps.
  function automatic int step_span();
    int longest;
    longest = int'(cfg_total) - int'(cfg_attack) - int'(cfg_return);
    if (int'(cfg_attack) > longest) longest = int'(cfg_attack);
    if (int'(cfg_return) > longest) longest = int'(cfg_return);
    return longest / 4 + 1;
  endfunction

  function automatic logic [15:0] pick_delta();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(step_span(), 0));
    endcase
  endfunction

  function automatic logic [15:0] pick_return_length();
    int cap;
    cap = step_span() * 4;
    if (cap > 65535) cap = 65535;
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(cap, 1));
    endcase
  endfunction

  // Mostly well-formed envelopes (start, ticks, maybe an early return or a stop)
  // with random content; about a fifth is pure noise.
  task automatic queue_random_items(input int n);
    int left;
    int k;
    int early_at;
    left = n;
    while (left > 0) begin
      if ($urandom_range(4) == 0) begin
        push_action(action_e'($urandom_range(3)), 16'($urandom_range(65535)),
                    16'($urandom_range(65535)));
        left--;
      end else begin
        push_action(ACT_START, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
        k        = int'($urandom_range(12, 1));
        early_at = ($urandom_range(2) == 0) ? int'($urandom_range(k - 1, 0)) : -1;
        for (int j = 0; j < k; j++) begin
          if (j == early_at) begin
            push_action(ACT_EARLY, 16'($urandom_range(65535)), pick_return_length());
            left--;
          end
          push_action(ACT_TICK, pick_delta(), 16'($urandom_range(65535)));
        end
        left -= k + 1;
        if ($urandom_range(4) == 0) begin
          push_action(ACT_STOP, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
          left--;
        end
      end
    end
  endtask

  // Block is idle once nothing is queued, in flight or still predicted;
  // looked at mid-cycle so that the driver's updates have settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (fade_actions.size() != 0 || in_ch.valid || envelope_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_TOTAL:  cfg_total  = val;
      CFG_ATTACK: cfg_attack = val;
      CFG_RETURN: cfg_return = val;
      default:    cfg_peak   = val;
    endcase
  endtask

  task automatic run_round(input logic [15:0] total, attack, ret, peak,
                           input int src, snk, n);
    wait_drained();
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_ATTACK, attack);
    write_reg(CFG_RETURN, ret);
    write_reg(CFG_MAXLVL, peak);
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    src_idle_pct   <= src;
    sink_stall_pct <= snk;
    queue_random_items(n);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_TOTAL;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings: hold lasts 500 - 50 - 300 = 150.
    // Idle actions: tick, early return and stop all leave it idle.
    push_action(ACT_TICK, 16'hFFFF, 16'hFFFF);
    push_action(ACT_EARLY, 16'h0000, 16'hFFFF);
    push_action(ACT_STOP, 16'hFFFF, 16'h0000);
    // Full envelope: empty tick, mid attack, exact attack end, hold edge,
    // mid return, then a saturating tick past the return end.
    push_action(ACT_START, '0, '0);
    push_action(ACT_TICK, 16'd0, '0);
    push_action(ACT_TICK, 16'd25, '0);
    push_action(ACT_TICK, 16'd25, '0);
    push_action(ACT_TICK, 16'd149, '0);
    push_action(ACT_TICK, 16'd1, '0);
    push_action(ACT_TICK, 16'd150, '0);
    push_action(ACT_TICK, 16'hFFFF, '0);
    // Restart while running, early return, re-triggered early return of
    // zero length, which ends on its first tick.
    push_action(ACT_START, '0, '0);
    push_action(ACT_START, '0, '0);
    push_action(ACT_TICK, 16'd10, '0);
    push_action(ACT_EARLY, '0, 16'd100);
    push_action(ACT_TICK, 16'd50, '0);
    push_action(ACT_EARLY, '0, 16'd0);
    push_action(ACT_TICK, 16'd0, '0);
    // Saturating tick through attack, then stop in hold.
    push_action(ACT_START, '0, '0);
    push_action(ACT_TICK, 16'hFFFF, '0);
    push_action(ACT_STOP, '0, '0);
    // Early return from level zero at full length; the timer lands exactly on the end.
    push_action(ACT_START, '0, '0);
    push_action(ACT_EARLY, '0, 16'hFFFF);
    push_action(ACT_TICK, 16'hFFFF, '0);

    // Random rounds across settings and idle profiles.
    run_round(16'd0, 16'd0, 16'd0, 16'd0, 0, 0, 45);
    run_round(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 46, 0, 45);
    run_round(16'd400, 16'd100, 16'd200, 16'hFFFF, 0, 46, 45);
    run_round(16'd100, 16'd300, 16'd200, 16'd1234, 20, 20, 45);  // negative hold
    run_round(16'd1000, 16'd64, 16'd64, 16'h8000, 0, 0, 45);
    run_round(16'($urandom_range(2000)), 16'($urandom_range(2000)),
              16'($urandom_range(2000)), 16'($urandom_range(65535)), 46, 0, 45);
    run_round(16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 0, 46, 45);       // long hold
    run_round(16'($urandom_range(2000)), 16'($urandom_range(2000)),
              16'($urandom_range(2000)), 16'($urandom_range(65535)), 20, 20, 45);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && envelope_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
